// ===== hdl/tasst_pkg.sv =====
`timescale 1ns / 1ps

package tasst_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned AXES    = 3;
  localparam int unsigned AXIS_W  = $clog2(AXES);
  localparam int unsigned STEP_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] RESET_X      = DATA_W'(120);
  localparam logic [DATA_W-1:0] RESET_Y      = DATA_W'(120);
  localparam logic [DATA_W-1:0] RESET_RADIUS = DATA_W'(1);

  localparam logic [AXIS_W-1:0] AXIS_X      = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_Y      = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] AXIS_RADIUS = AXIS_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_APPLY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_res_t;

endpackage

// ===== hdl/tasst_div.sv =====
`timescale 1ns / 1ps

module tasst_div
  import tasst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_res_t          res
);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] low;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] dvs;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DATA_W:0]   trial;
  logic              fits;

  // quotient is known to fit in DATA_W bits, so the upper half seeds the remainder
  assign trial = {rem, low[DATA_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[PROD_W-1:DATA_W];
      low  <= dividend[DATA_W-1:0];
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? DATA_W'(trial - {1'b0, dvs}) : trial[DATA_W-1:0];
      low  <= {low[DATA_W-2:0], 1'b0};
      quot <= {quot[DATA_W-2:0], fits};
    end
  end

  assign res.done = done;
  assign res.quot = quot;

endmodule

// ===== hdl/three_axis_scaled_step_to_target.sv =====
`timescale 1ns / 1ps

// Moves an eye position (x, y) and radius toward a target by one tick per input
// word. The axis with the largest distance moves by step_size, the others by
// step_size * diff / largest truncated toward zero, and no axis passes its
// target. When the block already sits on the target it goes straight to its
// output; otherwise one shared 8x8 multiplier and one restoring divider (one
// quotient bit per cycle) serve the three axes in turn. A new word is taken
// only while the block is idle, though a finished result may still be waiting
// on the output.
module three_axis_scaled_step_to_target
  import tasst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] target_x,
  input  logic [DATA_W-1:0] target_y,
  input  logic [DATA_W-1:0] target_radius,
  input  logic [DATA_W-1:0] step_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] pos_x,
  output logic [DATA_W-1:0] pos_y,
  output logic [DATA_W-1:0] pos_radius,
  output logic              settled
);

  state_t state;
  state_t state_next;

  logic [DATA_W-1:0] tgt [AXES];
  logic [DATA_W-1:0] cur [AXES];
  logic [DATA_W-1:0] mag [AXES];
  logic              neg [AXES];
  logic [DATA_W-1:0] step;
  logic [AXIS_W-1:0] axis;
  logic [PROD_W-1:0] prod;

  logic signed [DATA_W:0] diff [AXES];
  logic [DATA_W-1:0] mag_now [AXES];
  logic [DATA_W-1:0] largest;
  logic [DATA_W-1:0] largest_now;
  logic [DATA_W-1:0] move;
  logic              last_axis;
  logic              load_out;
  logic              div_start;
  div_res_t          div_res;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i]    = $signed({1'b0, tgt[i]}) - $signed({1'b0, cur[i]});
      mag_now[i] = diff[i][DATA_W] ? DATA_W'(-diff[i]) : diff[i][DATA_W-1:0];
    end
    largest_now = mag_now[0];
    if (mag_now[1] > largest_now) largest_now = mag_now[1];
    if (mag_now[2] > largest_now) largest_now = mag_now[2];
  end

  // clamp so the move never passes the target
  assign move      = (div_res.quot > mag[axis]) ? mag[axis] : div_res.quot;
  assign last_axis = axis == AXIS_RADIUS;
  assign in_stall  = state != S_IDLE;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIFF;
      end
      S_DIFF: begin
        state_next = (largest_now == '0) ? S_FIN : S_MUL;
      end
      S_MUL: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = last_axis ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cur[0]    <= RESET_X;
      cur[1]    <= RESET_Y;
      cur[2]    <= RESET_RADIUS;
      axis      <= AXIS_X;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == S_DIFF) axis <= AXIS_X;
      if (state == S_APPLY) begin
        cur[axis] <= neg[axis] ? cur[axis] - move : cur[axis] + move;
        if (!last_axis) axis <= axis + AXIS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      tgt[0] <= target_x;
      tgt[1] <= target_y;
      tgt[2] <= target_radius;
      step   <= step_size;
    end
    if (state == S_DIFF) begin
      for (int i = 0; i < AXES; i++) begin
        mag[i] <= mag_now[i];
        neg[i] <= diff[i][DATA_W];
      end
      largest <= largest_now;
    end
    if (state == S_MUL) prod <= PROD_W'(step) * PROD_W'(mag[axis]);
    if (load_out) begin
      pos_x      <= cur[0];
      pos_y      <= cur[1];
      pos_radius <= cur[2];
      settled    <= (cur[0] == tgt[0]) && (cur[1] == tgt[1]) && (cur[2] == tgt[2]);
    end
  end

  tasst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (largest),
    .res      (div_res)
  );

endmodule
